@@ sv/wgm_pkg.sv @@
// Shared types, constants and helpers of the wildcard glob matcher.
package wgm_pkg;

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int PATTERN_REG_BYTES   = 16;
  localparam int QUEUE_DEPTH         = 2;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_IDX_W           = 2;
  localparam int LEN_REG_W           = 5;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LOW  = 2'd0,
    REG_CHARS_HIGH = 2'd1,
    REG_LENGTH     = 2'd2
  } wgm_reg_e;

  typedef struct packed {
    logic [7:0] text_char;
    logic       char_present;
    logic       end_of_text;
  } wgm_text_t;

  typedef struct packed {
    logic matched;
  } wgm_result_t;

  typedef struct packed {
    logic char_present;
    logic end_of_text;
  } wgm_flags_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

@@ sv/wgm_stream_if.sv @@
// Valid/ready stream channel used for text items and match results.
interface wgm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/wgm_fifo.sv @@
// Small register queue between the classifying front and the automaton back end.
module wgm_fifo
  import wgm_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule

@@ sv/wgm_front.sv @@
// Front end: accepts text items and compares the character against every pattern position.
module wgm_front
  import wgm_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DEFAULT
) (
  wgm_stream_if.sink                   text_i,
  input  logic [MaxPattern-1:0][7:0]   pat_bytes_i,
  input  logic [MaxPattern-1:0]        use_mask_i,
  input  logic [MaxPattern-1:0]        star_mask_i,
  input  logic                         full_i,
  output logic                         push_o,
  output logic [MaxPattern-1:0]        adv_o,
  output wgm_flags_t                   flags_o
);
  logic [7:0] ch_fold;

  assign text_i.ready = !full_i;
  assign push_o       = text_i.valid && !full_i;
  assign ch_fold      = fold_case(text_i.payload.text_char);

  // A position advances on '?' or on an equal character; stars are handled in the back end.
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      adv_o[i] = use_mask_i[i] && !star_mask_i[i] &&
                 ((pat_bytes_i[i] == QMARK_CHAR) || (fold_case(pat_bytes_i[i]) == ch_fold));
    end
  end

  assign flags_o.char_present = text_i.payload.char_present;
  assign flags_o.end_of_text  = text_i.payload.end_of_text;
endmodule

@@ sv/wgm_back.sv @@
// Back end: steps the active-position vector and registers the match result.
module wgm_back
  import wgm_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  logic [MaxPattern-1:0]                adv_i,
  input  wgm_flags_t                           flags_i,
  input  logic [MaxPattern-1:0]                star_mask_i,
  input  logic [$clog2(MaxPattern+1)-1:0]      len_used_i,
  output logic                                 pop_o,
  wgm_stream_if.source                         result_o
);
  localparam int W      = MaxPattern + 1;
  localparam int Levels = $clog2(W);

  logic [W-1:0] active_q, active_d;
  logic [W-1:0] prop, cur, stepped, cur_next, home;
  logic         out_valid_q, out_valid_d;
  logic         matched_q, matched_d;

  // Parallel-prefix closure: a set position flows through every following star.
  function automatic logic [W-1:0] close_stars(input logic [W-1:0] set,
                                               input logic [W-1:0] pr);
    logic [W-1:0] g, p, gn, pn;
    g = set;
    p = pr;
    for (int l = 0; l < Levels; l++) begin
      gn = g;
      pn = p;
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << l)) begin
          gn[j] = g[j] | (p[j] & g[j - (1 << l)]);
          pn[j] = p[j] & p[j - (1 << l)];
        end
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

  assign prop    = {star_mask_i, 1'b0};
  assign cur     = close_stars(active_q, prop);
  assign stepped = {1'b0, cur[MaxPattern-1:0] & star_mask_i}
                 | {adv_i & cur[MaxPattern-1:0], 1'b0};
  assign cur_next = flags_i.char_present ? close_stars(stepped, prop) : cur;
  assign home    = close_stars(W'(1), prop);

  // Items that give no result never wait on the output register.
  assign pop_o = !empty_i &&
                 (!flags_i.end_of_text || !out_valid_q || result_o.ready);

  always_comb begin
    active_d    = active_q;
    out_valid_d = out_valid_q && !result_o.ready;
    matched_d   = matched_q;
    if (pop_o) begin
      if (flags_i.end_of_text) begin
        active_d    = home;
        out_valid_d = 1'b1;
        matched_d   = cur_next[len_used_i];
      end else begin
        active_d = cur_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= W'(1);
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.payload.matched = matched_q;
endmodule

@@ sv/wildcard_glob_matcher_core.sv @@
// Top level of the wildcard glob matcher: pattern registers, front end, queue and back end.
//
// Matches the pattern held in the configuration registers ('*' any run, '?' one character,
// ASCII letters without regard to case) against text streamed one character per item, and
// returns one match bit for each item flagged end_of_text. The block takes one item per
// cycle; result_o.valid rises once its item has left the queue. text_i.ready drops only
// when the two-entry queue is full, which happens while a finished result waits to be
// taken. The back end's combinational update of the active-position vector (two star
// closures and one step) sets the clock path. Write the pattern only while no item is in
// flight; the active set of a text string in progress is kept across such writes.
module wildcard_glob_matcher_core
  import wgm_pkg::*;
#(
  parameter int MaxPattern = MAX_PATTERN_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  wgm_stream_if.sink            text_i,
  wgm_stream_if.source          result_o
);
  localparam int LenW   = $clog2(MaxPattern + 1);
  localparam int EntryW = MaxPattern + $bits(wgm_flags_t);

  logic [CFG_DATA_W-1:0]       chars_low_q, chars_high_q;
  logic [LEN_REG_W-1:0]        length_q;
  logic [LenW-1:0]             len_used;
  logic [MaxPattern-1:0][7:0]  pat_bytes;
  logic [MaxPattern-1:0]       use_mask, star_mask;

  logic                        push, pop, full, empty;
  logic [MaxPattern-1:0]       adv_in, adv_out;
  wgm_flags_t                  flags_in, flags_out;
  logic [EntryW-1:0]           entry_in, entry_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_low_q  <= '0;
      chars_high_q <= '0;
      length_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHARS_LOW:  chars_low_q  <= cfg_wdata_i;
        REG_CHARS_HIGH: chars_high_q <= cfg_wdata_i;
        REG_LENGTH:     length_q     <= cfg_wdata_i[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to the pattern storage.
  always_comb begin
    if (int'(length_q) > MaxPattern) begin
      len_used = LenW'(MaxPattern);
    end else begin
      len_used = LenW'(length_q);
    end
  end

  for (genvar i = 0; i < MaxPattern; i++) begin : g_pos
    if (i < PATTERN_REG_BYTES / 2) begin : g_low
      assign pat_bytes[i] = chars_low_q[8*i +: 8];
    end else if (i < PATTERN_REG_BYTES) begin : g_high
      assign pat_bytes[i] = chars_high_q[8*(i - PATTERN_REG_BYTES / 2) +: 8];
    end else begin : g_none
      assign pat_bytes[i] = 8'h00;
    end
    assign use_mask[i]  = (LenW'(i) < len_used);
    assign star_mask[i] = use_mask[i] && (pat_bytes[i] == STAR_CHAR);
  end

  wgm_front #(
    .MaxPattern (MaxPattern)
  ) u_front (
    .text_i      (text_i),
    .pat_bytes_i (pat_bytes),
    .use_mask_i  (use_mask),
    .star_mask_i (star_mask),
    .full_i      (full),
    .push_o      (push),
    .adv_o       (adv_in),
    .flags_o     (flags_in)
  );

  assign entry_in  = {adv_in, flags_in};
  assign adv_out   = entry_out[EntryW-1 -: MaxPattern];
  assign flags_out = entry_out[$bits(wgm_flags_t)-1:0];

  wgm_fifo #(
    .Width (EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry_in),
    .pop_i   (pop),
    .rdata_o (entry_out),
    .full_o  (full),
    .empty_o (empty)
  );

  wgm_back #(
    .MaxPattern (MaxPattern)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .adv_i       (adv_out),
    .flags_i     (flags_out),
    .star_mask_i (star_mask),
    .len_used_i  (len_used),
    .pop_o       (pop),
    .result_o    (result_o)
  );
endmodule

@@ sv/wgm_checker.sv @@
// Port-level checker for the wildcard glob matcher and its bind to the top level.
module wgm_checker
  import wgm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_matched_i
);
  localparam int Capacity = QUEUE_DEPTH + 1;
  localparam int PendW    = $clog2(Capacity + 2);

  logic [PendW-1:0] pending_q;
  logic             in_last_acc, out_acc;

  assign in_last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc     = out_valid_i && out_ready_i;

  // Count results owed: accepted last items not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_last_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_last_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_matched_i))
    else $error("result dropped or changed while stalled");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result without an accepted last item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PendW'(Capacity))
    else $error("more results owed than the block can hold");

  a_no_accept_over_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == PendW'(Capacity) && !out_acc |-> !in_last_acc)
    else $error("last item accepted with queue and output full");
endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (text_i.valid),
  .in_ready_i    (text_i.ready),
  .in_last_i     (text_i.payload.end_of_text),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_matched_i (result_o.payload.matched)
);
